[rtl/lvam_pkg.sv]
// Shared constants and types for the limb vector ALU.
package lvam_pkg;

  localparam int LIMB_BITS = 64;
  localparam int SHIFT_BITS = 6;
  localparam int CNT_BITS = $clog2(LIMB_BITS + 1);

  typedef logic [LIMB_BITS-1:0] limb_t;

  typedef enum logic [3:0] {
    OP_SHADD   = 4'd0,
    OP_SHADD_C = 4'd1,
    OP_SHSUB   = 4'd2,
    OP_SHSUB_C = 4'd3,
    OP_RSUB_C  = 4'd4,
    OP_NEG     = 4'd5,
    OP_CONJ    = 4'd6,
    OP_NOT     = 4'd7,
    OP_ABS     = 4'd8,
    OP_MUL     = 4'd9,
    OP_MUL_C   = 4'd10,
    OP_DIV     = 4'd11,
    OP_DIV_C   = 4'd12,
    OP_RDIV_C  = 4'd13,
    OP_MAC     = 4'd14,
    OP_MAC2    = 4'd15
  } op_t;

  localparam logic [1:0] REG_OPERATION = 2'd0;
  localparam logic [1:0] REG_SHIFT_FIRST = 2'd1;
  localparam logic [1:0] REG_SHIFT_SECOND = 2'd2;
  localparam logic [1:0] REG_SCALAR = 2'd3;

endpackage

[rtl/limb_vector_alu_with_mac.sv]
// Top level of the limb vector ALU with multiply-accumulate.
// Each beat is worked by one shared adder under a sequencer, so the block takes one item
// at a time. Add, subtract, negate, not, abs and conjugate pass once through the adder.
// mul and mul_c use shift-and-add, one multiplier bit per cycle. mac adds the low limb of
// the product to its accumulator and gives its sum on the vector end. mac2 applies the
// signed correction to the product, adds both limbs with the carry, and gives its two sums
// on the vector end. Divides use restoring division, one quotient bit per cycle; a zero
// divisor skips the loop and sets divide_by_zero. While out_ready stays low on a result,
// the result is held and no new beat is taken.
// Results leave through an output register; mac2 sends the low limb and then the high limb.
module limb_vector_alu_with_mac
  import lvam_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] first_limb,
  input  logic [63:0] second_limb,
  input  logic        vector_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] result_limb,
  output logic        result_final,
  output logic        divide_by_zero
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_ADD, S_MUL, S_MCOR1, S_MCOR2, S_MACC, S_MACC2,
    S_DIV, S_DFIX, S_OUT, S_OUT2
  } state_t;

  state_t state;
  op_t    operation;
  logic [SHIFT_BITS-1:0] shift_first, shift_second;
  limb_t  scalar_operand;
  limb_t  acc_lo, acc_hi;
  logic   odd_position;

  // Working registers of the sequencer.
  limb_t  opa, opb;       // adder operands / dividend and divisor
  logic   sub;            // adder subtracts
  limb_t  prod_lo, prod_hi;
  limb_t  rem, quo;
  logic   neg_q;
  logic   last;
  logic [CNT_BITS-1:0] cnt;
  limb_t  mul_a, mul_b;

  // The shared adder.
  logic [LIMB_BITS:0] sum;
  limb_t add_x, add_y;
  logic  add_sub;

  limb_t a_in, b_in, x_sh, y_sh;
  assign a_in = first_limb[LIMB_BITS-1:0];
  assign b_in = second_limb[LIMB_BITS-1:0];
  assign x_sh = a_in << shift_first;
  assign y_sh = b_in << shift_second;

  limb_t rem_sh;
  assign rem_sh = {rem[LIMB_BITS-2:0], quo[LIMB_BITS-1]};

  always_comb begin
    add_x = opa;
    add_y = opb;
    add_sub = sub;
    unique case (state)
      S_MUL: begin
        add_x = prod_hi;
        add_y = prod_lo[0] ? mul_a : '0;
        add_sub = 1'b0;
      end
      S_MCOR1: begin
        add_x = prod_hi;
        add_y = mul_a[LIMB_BITS-1] ? mul_b : '0;
        add_sub = 1'b1;
      end
      S_MCOR2: begin
        add_x = prod_hi;
        add_y = mul_b[LIMB_BITS-1] ? mul_a : '0;
        add_sub = 1'b1;
      end
      S_MACC: begin
        add_x = acc_lo;
        add_y = prod_lo;
        add_sub = 1'b0;
      end
      S_MACC2: begin
        add_x = acc_hi;
        add_y = prod_hi + limb_t'(sub);
        add_sub = 1'b0;
      end
      S_DIV: begin
        add_x = rem_sh;
        add_y = opb;
        add_sub = 1'b1;
      end
      S_DFIX: begin
        add_x = '0;
        add_y = quo;
        add_sub = neg_q;
      end
      default: ;
    endcase
    sum = add_sub ? {1'b0, add_x} - {1'b0, add_y} : {1'b0, add_x} + {1'b0, add_y};
  end

  assign pready = 1'b1;
  assign in_ready = (state == S_IDLE);

  // Register read mux.
  always_comb begin
    unique case (paddr[4:3])
      REG_OPERATION:    prdata = {60'd0, operation};
      REG_SHIFT_FIRST:  prdata = {58'd0, shift_first};
      REG_SHIFT_SECOND: prdata = {58'd0, shift_second};
      default:          prdata = scalar_operand;
    endcase
  end

  limb_t n_abs, d_abs;
  always_comb begin
    n_abs = opa[LIMB_BITS-1] ? -opa : opa;
    d_abs = opb[LIMB_BITS-1] ? -opb : opb;
  end

  // Sequencer, state and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      operation <= OP_SHADD;
      shift_first <= '0;
      shift_second <= '0;
      scalar_operand <= '0;
      acc_lo <= '0;
      acc_hi <= '0;
      odd_position <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (paddr[4:3])
          REG_OPERATION:    operation <= op_t'(pwdata[3:0]);
          REG_SHIFT_FIRST:  shift_first <= pwdata[SHIFT_BITS-1:0];
          REG_SHIFT_SECOND: shift_second <= pwdata[SHIFT_BITS-1:0];
          default:          scalar_operand <= pwdata[LIMB_BITS-1:0];
        endcase
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          last <= vector_end;
          sub <= 1'b0;
          mul_a <= a_in;
          mul_b <= b_in;
          cnt <= '0;
          odd_position <= vector_end ? 1'b0 : ~odd_position;
          state <= S_ADD;
          case (operation) inside
            OP_SHADD:   begin opa <= x_sh; opb <= y_sh; end
            OP_SHADD_C: begin opa <= x_sh; opb <= scalar_operand; end
            OP_SHSUB:   begin opa <= x_sh; opb <= y_sh; sub <= 1'b1; end
            OP_SHSUB_C: begin opa <= x_sh; opb <= scalar_operand; sub <= 1'b1; end
            OP_RSUB_C:  begin opa <= scalar_operand; opb <= a_in; sub <= 1'b1; end
            OP_NEG:     begin opa <= '0; opb <= a_in; sub <= 1'b1; end
            OP_CONJ:    begin opa <= '0; opb <= a_in; sub <= odd_position; end
            OP_NOT:     begin opa <= ~a_in; opb <= '0; end
            OP_ABS:     begin opa <= '0; opb <= a_in; sub <= a_in[LIMB_BITS-1]; end
            OP_MUL, OP_MAC, OP_MAC2: begin
              prod_lo <= b_in; prod_hi <= '0; state <= S_MUL;
            end
            OP_MUL_C: begin
              mul_b <= scalar_operand; prod_lo <= scalar_operand; prod_hi <= '0;
              state <= S_MUL;
            end
            OP_DIV:   begin opa <= x_sh; opb <= b_in; state <= S_PREP; end
            OP_DIV_C: begin opa <= x_sh; opb <= scalar_operand; state <= S_PREP; end
            default:  begin opa <= scalar_operand; opb <= a_in; state <= S_PREP; end
          endcase
        end
        S_ADD: begin
          result_limb <= 64'(sum[LIMB_BITS-1:0]);
          result_final <= 1'b1;
          divide_by_zero <= 1'b0;
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_MUL: begin
          {prod_hi, prod_lo} <= {sum, prod_lo[LIMB_BITS-1:1]};
          cnt <= cnt + 1'b1;
          if (cnt == CNT_BITS'(LIMB_BITS - 1)) begin
            if (operation == OP_MAC2) state <= S_MCOR1;
            else state <= S_MACC;
          end
        end
        S_MCOR1: begin prod_hi <= sum[LIMB_BITS-1:0]; state <= S_MCOR2; end
        S_MCOR2: begin prod_hi <= sum[LIMB_BITS-1:0]; state <= S_MACC; end
        S_MACC: begin
          if (operation == OP_MUL || operation == OP_MUL_C) begin
            result_limb <= 64'(prod_lo);
            result_final <= 1'b1;
            divide_by_zero <= 1'b0;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            acc_lo <= sum[LIMB_BITS-1:0];
            sub <= sum[LIMB_BITS];
            state <= (operation == OP_MAC2) ? S_MACC2 : S_OUT2;
          end
        end
        S_MACC2: begin
          acc_hi <= sum[LIMB_BITS-1:0];
          state <= S_OUT2;
        end
        S_OUT2: begin
          // Accumulate results, then clear on the vector end.
          if (last) begin
            result_limb <= 64'(acc_lo);
            result_final <= (operation == OP_MAC);
            divide_by_zero <= 1'b0;
            out_valid <= 1'b1;
            acc_lo <= '0;
            state <= S_OUT;
            if (operation == OP_MAC) acc_hi <= '0;
          end else state <= S_IDLE;
        end
        S_PREP: begin
          if (opb == '0) begin
            result_limb <= '0;
            result_final <= 1'b1;
            divide_by_zero <= 1'b1;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            neg_q <= opa[LIMB_BITS-1] ^ opb[LIMB_BITS-1];
            quo <= n_abs;
            opb <= d_abs;
            rem <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (!sum[LIMB_BITS]) begin
            rem <= sum[LIMB_BITS-1:0];
            quo <= {quo[LIMB_BITS-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[LIMB_BITS-2:0], 1'b0};
          end
          if (cnt == CNT_BITS'(LIMB_BITS - 1)) state <= S_DFIX;
        end
        S_DFIX: begin
          result_limb <= 64'(neg_q ? sum[LIMB_BITS-1:0] : quo);
          result_final <= 1'b1;
          divide_by_zero <= 1'b0;
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          if (!result_final) begin
            result_limb <= 64'(acc_hi);
            result_final <= 1'b1;
            acc_hi <= '0;
          end else begin
            out_valid <= 1'b0;
            if (last) begin
              acc_lo <= '0;
              acc_hi <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/lvam_checker.sv]
// Port-level assertions for the limb vector ALU, bound to the top level.
module lvam_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic result_final,
  input logic divide_by_zero,
  input logic [63:0] result_limb
);

  // The block never takes a beat while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  // A flagged divide result is zero and final.
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_by_zero) |-> (result_limb == 64'd0 && result_final))
    else $error("bad divide-by-zero result");

  // A held result stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(result_limb)))
    else $error("result changed under stall");

  // A non-final beat is followed by more output.
  a_pair: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !result_final) |=> out_valid)
    else $error("high limb missing");

endmodule

bind limb_vector_alu_with_mac lvam_checker u_lvam_checker (.*);

[tb/limb_vector_alu_with_mac_checker.sv]
// Checker for the limb vector ALU: tracks register writes, predicts results, compares beats.
module limb_vector_alu_with_mac_checker
  import lvam_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] first_limb,
  input  logic [63:0] second_limb,
  input  logic        vector_end,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] result_limb,
  input  logic        result_final,
  input  logic        divide_by_zero,
  output int          error_count,
  output int          results_pending,
  output int          results_seen
);

  typedef struct packed {
    logic [63:0] limb;
    logic        final_flag;
    logic        dbz;
  } limb_result_t;

  limb_result_t expected_results[$];

  // Shadow copy of the configuration and of the block's running state.
  op_t          cur_op;
  logic [5:0]   cur_shift_first;
  logic [5:0]   cur_shift_second;
  limb_t        cur_scalar;
  logic [127:0] acc;
  logic         odd_pos;

  // Signed truncating quotient; a zero divisor gives zero and sets the flag.
  function automatic limb_t signed_quotient(input limb_t n, input limb_t d, output logic z);
    limb_t mn, md, q;
    z = 1'b0;
    if (d == '0) begin
      z = 1'b1;
      return '0;
    end
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q = mn / md;
    return (n[63] ^ d[63]) ? -q : q;
  endfunction

  // Works out the results of one accepted beat and advances the state.
  task automatic predict_beat(input limb_t a, input limb_t b, input logic last);
    limb_t x, y, r;
    logic z;
    logic signed [127:0] prod;
    int count;
    x = a << cur_shift_first;
    y = b << cur_shift_second;
    r = '0;
    z = 1'b0;
    count = 1;
    case (cur_op)
      OP_SHADD:   r = x + y;
      OP_SHADD_C: r = x + cur_scalar;
      OP_SHSUB:   r = x - y;
      OP_SHSUB_C: r = x - cur_scalar;
      OP_RSUB_C:  r = cur_scalar - a;
      OP_NEG:     r = -a;
      OP_CONJ:    r = odd_pos ? -a : a;
      OP_NOT:     r = ~a;
      OP_ABS:     r = a[63] ? -a : a;
      OP_MUL:     r = a * b;
      OP_MUL_C:   r = a * cur_scalar;
      OP_DIV:     r = signed_quotient(x, b, z);
      OP_DIV_C:   r = signed_quotient(x, cur_scalar, z);
      OP_RDIV_C:  r = signed_quotient(cur_scalar, a, z);
      OP_MAC: begin
        acc[63:0] = acc[63:0] + a * b;
        r = acc[63:0];
        count = last ? 1 : 0;
      end
      default: begin
        prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        acc = acc + prod;
        count = last ? 2 : 0;
      end
    endcase
    if (count == 1) begin
      expected_results.push_back('{r, 1'b1, z});
    end else if (count == 2) begin
      expected_results.push_back('{acc[63:0], 1'b0, 1'b0});
      expected_results.push_back('{acc[127:64], 1'b1, 1'b0});
    end
    odd_pos = !odd_pos;
    if (last) begin
      odd_pos = 1'b0;
      acc = '0;
    end
  endtask

  // Register writes, input beats and result beats, all sampled at the rising edge.
  always @(posedge clk) begin
    limb_result_t e;
    if (rst) begin
      cur_op = OP_SHADD;
      cur_shift_first = '0;
      cur_shift_second = '0;
      cur_scalar = '0;
      acc = '0;
      odd_pos = 1'b0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          REG_OPERATION:    cur_op = op_t'(pwdata[3:0]);
          REG_SHIFT_FIRST:  cur_shift_first = pwdata[5:0];
          REG_SHIFT_SECOND: cur_shift_second = pwdata[5:0];
          default:          cur_scalar = pwdata;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_beat(first_limb, second_limb, vector_end);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: limb %h", result_limb);
          error_count++;
        end else begin
          e = expected_results.pop_front();
          if (result_limb !== e.limb) begin
            $error("result_limb: expected %h, got %h", e.limb, result_limb);
            error_count++;
          end
          if (result_final !== e.final_flag) begin
            $error("result_final: expected %b, got %b", e.final_flag, result_final);
            error_count++;
          end
          if (divide_by_zero !== e.dbz) begin
            $error("divide_by_zero: expected %b, got %b", e.dbz, divide_by_zero);
            error_count++;
          end
        end
      end
    end
    results_pending = expected_results.size();
  end

  initial begin
    error_count = 0;
    results_pending = 0;
    results_seen = 0;
  end

endmodule

[tb/limb_vector_alu_with_mac_tb.sv]
// Testbench top for the limb vector ALU: clock, reset, stimulus and verdict.
module limb_vector_alu_with_mac_tb;
  import lvam_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid, in_ready;
  logic [63:0] first_limb, second_limb;
  logic        vector_end;
  logic        out_valid, out_ready;
  logic [63:0] result_limb;
  logic        result_final, divide_by_zero;

  int error_count, results_pending, results_seen;
  int beats_sent;
  int cycle_count;
  logic calm;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 200;
  localparam limb_t MOST_NEG = 64'h8000_0000_0000_0000;
  localparam limb_t MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;

  limb_vector_alu_with_mac dut (.*);

  limb_vector_alu_with_mac_checker checker_inst (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle counter with a hard stop.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side stalls at random except during the calm stretch.
  always @(negedge clk) begin
    out_ready = calm || ($urandom_range(0, 99) >= 27);
  end

  // Operand values biased toward the edges of the signed range.
  function automatic limb_t pick_limb();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return MOST_NEG;
      3: return MOST_POS;
      4: return limb_t'($urandom_range(0, 20));
      5: return -limb_t'($urandom_range(1, 20));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One register write: a setup phase, then an access phase.
  task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {index, 3'b000};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Waits for the block to drain, then loads a full configuration.
  task automatic configure(input op_t op, input logic [5:0] s1, input logic [5:0] s2,
                           input limb_t scalar);
    in_valid = 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    write_reg(REG_OPERATION, 64'(op));
    write_reg(REG_SHIFT_FIRST, 64'(s1));
    write_reg(REG_SHIFT_SECOND, 64'(s2));
    write_reg(REG_SCALAR, scalar);
  endtask

  // Sends one input beat, with a random gap ahead of it outside the calm stretch.
  task automatic send_beat(input limb_t a, input limb_t b, input logic last);
    while (!calm && $urandom_range(0, 99) < 27) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    first_limb = a;
    second_limb = b;
    vector_end = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  initial begin
    op_t op;
    int n;
    rst = 1'b1;
    calm = 1'b0;
    cycle_count = 0;
    beats_sent = 0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    first_limb = '0;
    second_limb = '0;
    vector_end = 1'b0;
    out_ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: plain add at reset settings, then the divide corner cases.
    send_beat('1, 64'd1, 1'b0);
    configure(OP_DIV, 6'd0, 6'd0, '0);
    send_beat(MOST_NEG, '1, 1'b0);
    send_beat(64'd100, '0, 1'b0);
    send_beat(-limb_t'(7), 64'd2, 1'b1);
    configure(OP_DIV_C, 6'd63, 6'd0, '0);
    send_beat(64'd3, 64'd0, 1'b0);
    configure(OP_RDIV_C, 6'd0, 6'd63, MOST_NEG);
    send_beat('0, '1, 1'b0);
    send_beat('1, '0, 1'b0);
    // Abs and negate of the most negative value, and abs of a small negative value.
    configure(OP_ABS, 6'd0, 6'd0, '1);
    send_beat(MOST_NEG, '0, 1'b0);
    send_beat(-limb_t'(5), '0, 1'b0);
    configure(OP_NEG, 6'd0, 6'd0, '1);
    send_beat(MOST_NEG, '0, 1'b0);
    // Conjugate parity across a vector end.
    configure(OP_CONJ, 6'd0, 6'd0, '0);
    send_beat(64'd9, '0, 1'b0);
    send_beat(64'd9, '0, 1'b0);
    send_beat(64'd9, '0, 1'b1);
    send_beat(64'd9, '0, 1'b0);
    // Accumulations, a mode change inside a vector, and single-beat vectors.
    configure(OP_MAC2, 6'd0, 6'd0, '0);
    send_beat(MOST_NEG, MOST_NEG, 1'b0);
    send_beat('1, MOST_POS, 1'b0);
    send_beat(MOST_NEG, MOST_POS, 1'b1);
    send_beat(64'd3, 64'd4, 1'b0);
    configure(OP_MAC, 6'd0, 6'd0, '0);
    send_beat('1, '1, 1'b1);
    send_beat(64'd5, 64'd6, 1'b1);

    // Random phases: every operation first, then random ones with random settings.
    for (int phase = 0; phase < 48; phase++) begin
      op = (phase < 16) ? op_t'(phase) : op_t'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0: configure(op, 6'd0, 6'd0, pick_limb());
        1: configure(op, 6'd63, 6'd63, pick_limb());
        default: configure(op, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                           pick_limb());
      endcase
      calm = (phase >= 20 && phase < 26);
      n = $urandom_range(12, 30);
      for (int i = 0; i < n; i++) begin
        send_beat(pick_limb(), pick_limb(), $urandom_range(0, 5) == 0);
      end
    end
    calm = 1'b0;
    in_valid = 1'b0;

    // Drain, then give the verdict.
    while (results_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered all 16 operations over many register settings");
    $display("%0d input beats sent, %0d result beats checked", beats_sent, results_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
